// ===== rtl/core/kllc_pkg.sv =====
// ----------------------------------------------------------------------------
// kllc_pkg: shared constants for the length-limited code length block
// Stream word widths, length limits and the log2(1.5) constant.
// ----------------------------------------------------------------------------
package kllc_pkg;

	// longest code length the block supports
	localparam int LIM_MAX = 24;
	// code length field width
	localparam int LEN_W = 5;
	// configuration word width
	localparam int CFG_W = 5;
	// input word: count[31:0], symbol_index[40:32], zero fill to 48
	localparam int S_TDATA_W = 48;
	localparam int S_COUNT_W = 32;
	localparam int S_INDEX_W = 9;
	// output word: code_length[4:0], longest_length[9:5], zero fill to 16
	localparam int M_TDATA_W = 16;
	// log2(1.5) in Q30
	localparam logic [29:0] LOG2_C_Q30 = 30'd628098702;
	localparam int C_FRAC = 30;

endpackage

// ===== rtl/core/kllc_ram.sv =====
// ----------------------------------------------------------------------------
// kllc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kllc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/kraft_length_limited_code_lengths.sv =====
// ----------------------------------------------------------------------------
// kraft_length_limited_code_lengths: prefix code lengths under a length limit
// Loads symbol counts, estimates ideal lengths with a shared shift/subtract
// divider, then lengthens codes until the Kraft sum fits and shortens into the slack.
// ----------------------------------------------------------------------------
// Loads: one word per cycle while the output is not stalled, no result. Reads:
// input is held off while a read is pending; the result goes through the length
// RAM read register and the output register. A load marked last starts the
// computation: per symbol estimate (normalize, divide, multiply, length), then
// lengthening passes, one shortening pass and the search for the longest length.
// Input is not ready during computation. Reset clears counters and flags and
// sets max_length to 15; the RAMs are not cleared.
module kraft_length_limited_code_lengths #(
	parameter int NUM_SYMBOLS   = 512,
	parameter int COUNT_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: max_length[4:0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kllc_pkg::CFG_W-1:0]    cfg_data,
	// s_tdata: count[31:0], symbol_index[40:32]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [kllc_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: mode[0]
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	// m_tdata: code_length[4:0], longest_length[9:5]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [kllc_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser: failed[0]
	output logic                          m_tuser
);

	localparam int F     = FRACTION_BITS;
	localparam int IDX_W = $clog2(NUM_SYMBOLS);
	localparam int LW    = $clog2(NUM_SYMBOLS + 1);
	localparam int TW    = COUNT_BITS + IDX_W;
	localparam int KBW   = $clog2(TW + 2);
	localparam int BW    = $clog2(F + 1);
	localparam int ENT_W = F + 8;
	localparam int DW    = ENT_W + 2;
	localparam int KW    = kllc_pkg::LIM_MAX + IDX_W + 1;
	localparam int PW    = kllc_pkg::C_FRAC + F + 1;
	localparam int CW    = (LW > kllc_pkg::S_INDEX_W) ? LW : kllc_pkg::S_INDEX_W;
	localparam int LEN_W = kllc_pkg::LEN_W;
	localparam int M_TDATA_W_L = kllc_pkg::M_TDATA_W;
	localparam logic [29:0] LOG2_C_Q30_L = kllc_pkg::LOG2_C_Q30;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_CHK   = 14'b00000000000010,
		ST_E_RD  = 14'b00000000000100,
		ST_E_LD  = 14'b00000000001000,
		ST_E_SH  = 14'b00000000010000,
		ST_E_DV  = 14'b00000000100000,
		ST_E_MUL = 14'b00000001000000,
		ST_E_LEN = 14'b00000010000000,
		ST_L_RD  = 14'b00000100000000,
		ST_L_EV  = 14'b00001000000000,
		ST_S_RD  = 14'b00010000000000,
		ST_S_EV  = 14'b00100000000000,
		ST_M_RD  = 14'b01000000000000,
		ST_M_EV  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]      max_len_q;
	logic [LW-1:0]         loaded_q;
	logic [LW-1:0]         used_q;
	logic [LW-1:0]         computed_q;
	logic [LW-1:0]         i_q;
	logic [TW-1:0]         total_q;
	logic [KW-1:0]         kraft_q;
	logic signed [DW-1:0]  thr_q;
	logic [LEN_W-1:0]      longest_q;
	logic                  fail_q;
	logic [TW:0]           n_q;
	logic [TW-1:0]         r_q;
	logic [F:0]            m_q;
	logic [KBW-1:0]        k_q;
	logic [BW-1:0]         b_q;
	logic [PW-1:0]         prod_q;
	logic                  rd_pend_q;
	logic                  rd_hit_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W_L-1:0] m_tdata_q;
	logic                  m_tuser_q;

	// RAM ports
	logic                  cnt_we;
	logic [IDX_W-1:0]      cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  len_we;
	logic [IDX_W-1:0]      len_waddr;
	logic [LEN_W-1:0]      len_wdata;
	logic [IDX_W-1:0]      len_raddr;
	logic [LEN_W-1:0]      len_rd;
	logic                  ent_we;
	logic [ENT_W-1:0]      ent_wdata;
	logic [ENT_W-1:0]      ent_rd;

	// input fields
	logic                  in_acc;
	logic                  in_mode;
	logic [COUNT_BITS-1:0] in_cnt;
	logic [CW-1:0]         in_idx;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign in_mode   = s_tuser;
	assign in_cnt    = s_tdata[COUNT_BITS-1:0];
	assign in_idx    = CW'(s_tdata[kllc_pkg::S_COUNT_W +: kllc_pkg::S_INDEX_W]);
	assign s_tready  = (state_q == ST_IDLE) && !rd_pend_q && (!m_tvalid_q || m_tready);

	// saturated limit and the Kraft unit
	logic [LEN_W-1:0] lim;
	logic [KW-1:0]    one_k;
	always_comb begin
		if (max_len_q == '0) begin
			lim = LEN_W'(1);
		end else if (max_len_q > LEN_W'(kllc_pkg::LIM_MAX)) begin
			lim = LEN_W'(kllc_pkg::LIM_MAX);
		end else begin
			lim = max_len_q;
		end
		one_k = KW'(1) << lim;
	end

	logic             i_end;
	logic [IDX_W-1:0] addr_i;
	assign i_end  = (i_q == computed_q);
	assign addr_i = i_q[IDX_W-1:0];

	// estimate finish: entropy and rounded, clamped length
	logic [PW-1:0]           prod_rnd;
	logic [F:0]              term;
	logic signed [ENT_W-1:0] ent_new;
	logic signed [ENT_W:0]   v_rnd;
	logic [ENT_W-F-1:0]      len_raw;
	logic [LEN_W-1:0]        len_est;
	always_comb begin
		prod_rnd = prod_q + (PW'(1) << (kllc_pkg::C_FRAC - 1));
		term     = prod_rnd[kllc_pkg::C_FRAC +: F + 1];
		ent_new  = $signed((ENT_W'(k_q) << F) - ENT_W'(term));
		v_rnd    = (ENT_W + 1)'(ent_new) + $signed((ENT_W + 1)'(1) << (F - 1));
		len_raw  = v_rnd[ENT_W] ? '0 : v_rnd[ENT_W-1:F];
		if (len_raw == '0) begin
			len_est = LEN_W'(1);
		end else if (len_raw > (ENT_W - F)'(lim)) begin
			len_est = lim;
		end else begin
			len_est = LEN_W'(len_raw);
		end
	end

	// lengthening test
	logic signed [DW-1:0] diff;
	logic                 lcond;
	logic [KW-1:0]        kraft_dec;
	always_comb begin
		diff      = $signed(DW'($signed(ent_rd))) - $signed(DW'(len_rd) << F);
		lcond     = (len_rd != '0) && (len_rd < lim) && (diff > thr_q);
		kraft_dec = kraft_q - (KW'(1) << (lim - len_rd - LEN_W'(1)));
	end

	// shortening test
	logic [KW-1:0] have;
	logic          scond;
	always_comb begin
		have  = KW'(1) << (lim - len_rd);
		scond = (len_rd > LEN_W'(1)) && ((one_k - kraft_q) >= have);
	end

	// divider step
	logic [TW:0] r_dbl;
	logic        r_ge;
	assign r_dbl = {r_q, 1'b0};
	assign r_ge  = r_dbl >= {1'b0, total_q};

	// RAM controls
	always_comb begin
		cnt_we    = in_acc && !in_mode && (loaded_q < LW'(NUM_SYMBOLS));
		cnt_raddr = addr_i;
		len_we    = 1'b0;
		len_waddr = addr_i;
		len_wdata = len_est;
		len_raddr = (state_q == ST_IDLE) ? in_idx[IDX_W-1:0] : addr_i;
		ent_we    = 1'b0;
		ent_wdata = ent_new;
		case (state_q)
			ST_E_LD: begin
				if (cnt_rd == '0) begin
					len_we    = 1'b1;
					len_wdata = '0;
				end
			end
			ST_E_LEN: begin
				len_we = 1'b1;
				ent_we = 1'b1;
			end
			ST_L_EV: begin
				len_we    = lcond;
				len_wdata = len_rd + LEN_W'(1);
			end
			ST_S_EV: begin
				len_we    = scond;
				len_wdata = len_rd - LEN_W'(1);
			end
			default: begin
			end
		endcase
	end

	kllc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SYMBOLS)) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(loaded_q[IDX_W-1:0]),
		.wdata(in_cnt),
		.raddr(cnt_raddr),
		.rdata(cnt_rd)
	);

	kllc_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SYMBOLS)) u_len_ram (
		.clk  (clk),
		.we   (len_we),
		.waddr(len_waddr),
		.wdata(len_wdata),
		.raddr(len_raddr),
		.rdata(len_rd)
	);

	kllc_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SYMBOLS)) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(addr_i),
		.wdata(ent_wdata),
		.raddr(addr_i),
		.rdata(ent_rd)
	);

	// pass decision when the estimate or a lengthening pass ends
	function automatic state_t pick_pass(input logic [KW-1:0] kr, input logic [KW-1:0] one);
		state_t s;
		if (kr > one) begin
			s = ST_L_RD;
		end else if (kr < one) begin
			s = ST_S_RD;
		end else begin
			s = ST_M_RD;
		end
		return s;
	endfunction

	localparam logic signed [DW-1:0] THR_INIT = DW'(28) << (F - 6);
	localparam logic signed [DW-1:0] THR_STEP = DW'(1) << (F - 6);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_len_q  <= LEN_W'(15);
			loaded_q   <= '0;
			used_q     <= '0;
			computed_q <= '0;
			i_q        <= '0;
			total_q    <= '0;
			kraft_q    <= '0;
			thr_q      <= THR_INIT;
			longest_q  <= '0;
			fail_q     <= 1'b0;
			n_q        <= '0;
			r_q        <= '0;
			m_q        <= '0;
			k_q        <= '0;
			b_q        <= '0;
			prod_q     <= '0;
			rd_pend_q  <= 1'b0;
			rd_hit_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			// configuration write
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			// load the pending read, else drop a taken result
			rd_pend_q <= in_acc && in_mode;
			if (rd_pend_q) begin
				m_tvalid_q <= 1'b1;
				m_tuser_q  <= fail_q;
				m_tdata_q  <= M_TDATA_W_L'({(fail_q ? LEN_W'(0) : longest_q),
					(rd_hit_q ? len_rd : LEN_W'(0))});
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_mode) begin
						rd_hit_q  <= !fail_q && (in_idx < CW'(computed_q));
					end else if (in_acc) begin
						if (loaded_q < LW'(NUM_SYMBOLS)) begin
							loaded_q <= loaded_q + LW'(1);
							total_q  <= total_q + TW'(in_cnt);
							if (in_cnt != '0) begin
								used_q <= used_q + LW'(1);
							end
						end
						if (s_tlast) begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					computed_q <= loaded_q;
					kraft_q    <= '0;
					thr_q      <= THR_INIT;
					longest_q  <= '0;
					i_q        <= '0;
					fail_q     <= KW'(used_q) > one_k;
					if (KW'(used_q) > one_k) begin
						loaded_q <= '0;
						total_q  <= '0;
						used_q   <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_E_RD;
					end
				end
				ST_E_RD: begin
					if (i_end) begin
						i_q     <= '0;
						state_q <= pick_pass(kraft_q, one_k);
					end else begin
						state_q <= ST_E_LD;
					end
				end
				ST_E_LD: begin
					if (cnt_rd == '0) begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_E_RD;
					end else begin
						n_q     <= (TW + 1)'(cnt_rd);
						k_q     <= '0;
						state_q <= ST_E_SH;
					end
				end
				ST_E_SH: begin
					// normalize count up to the total
					if (n_q < {1'b0, total_q}) begin
						n_q <= {n_q[TW-1:0], 1'b0};
						k_q <= k_q + KBW'(1);
					end else begin
						r_q     <= TW'(n_q - {1'b0, total_q});
						m_q     <= (F + 1)'(1);
						b_q     <= '0;
						state_q <= ST_E_DV;
					end
				end
				ST_E_DV: begin
					// one quotient bit per cycle
					r_q <= r_ge ? TW'(r_dbl - {1'b0, total_q}) : r_dbl[TW-1:0];
					m_q <= {m_q[F-1:0], r_ge};
					b_q <= b_q + BW'(1);
					if (b_q == BW'(F - 1)) begin
						state_q <= ST_E_MUL;
					end
				end
				ST_E_MUL: begin
					prod_q  <= PW'(LOG2_C_Q30_L) * PW'(m_q);
					state_q <= ST_E_LEN;
				end
				ST_E_LEN: begin
					kraft_q <= kraft_q + (KW'(1) << (lim - len_est));
					i_q     <= i_q + LW'(1);
					state_q <= ST_E_RD;
				end
				ST_L_RD: begin
					if (i_end) begin
						thr_q   <= thr_q - THR_STEP;
						i_q     <= '0;
						state_q <= pick_pass(kraft_q, one_k);
					end else begin
						state_q <= ST_L_EV;
					end
				end
				ST_L_EV: begin
					if (lcond) begin
						kraft_q <= kraft_dec;
					end
					if (lcond && kraft_dec <= one_k) begin
						thr_q   <= thr_q - THR_STEP;
						i_q     <= '0;
						state_q <= pick_pass(kraft_dec, one_k);
					end else begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_L_RD;
					end
				end
				ST_S_RD: begin
					if (i_end) begin
						i_q     <= '0;
						state_q <= ST_M_RD;
					end else begin
						state_q <= ST_S_EV;
					end
				end
				ST_S_EV: begin
					if (scond) begin
						kraft_q <= kraft_q + have;
					end
					if (scond && (kraft_q + have) == one_k) begin
						i_q     <= '0;
						state_q <= ST_M_RD;
					end else begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_S_RD;
					end
				end
				ST_M_RD: begin
					if (i_end) begin
						loaded_q <= '0;
						total_q  <= '0;
						used_q   <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_M_EV;
					end
				end
				ST_M_EV: begin
					if (len_rd > longest_q) begin
						longest_q <= len_rd;
					end
					i_q     <= i_q + LW'(1);
					state_q <= ST_M_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// input is taken only while idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input ready outside idle");

	// a pending read always lands in the output register
	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |=> m_tvalid_q)
		else $error("pending read lost");

	// divider remainder stays below the total
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_DV) |-> (r_q < total_q))
		else $error("divider remainder out of range");

	// a shortening pass never overshoots the Kraft limit
	a_kraft_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_EV) |=> (kraft_q <= one_k))
		else $error("Kraft sum above one after shortening");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the length-limited code length block
// Streams symbol-count blocks with random content and limits, reads the code
// lengths back and checks every read word against an in-bench code length
// calculator that runs the same Kraft heuristic at the block's widths.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NSYM   = 512;
	localparam int FB     = 16;
	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_READ = 1'b1;
	localparam int SETTLE = 64;

	typedef struct packed {
		logic [kllc_pkg::LEN_W-1:0] code;
		logic [kllc_pkg::LEN_W-1:0] longest;
		logic                       failed;
	} length_word_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [kllc_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [kllc_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [kllc_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	// calculator state
	logic [31:0]                sym_count [NSYM];
	logic [kllc_pkg::LEN_W-1:0] sym_len [NSYM];
	longint                     sym_est [NSYM];
	int                         n_loaded;
	longint unsigned            count_sum;
	logic [4:0]                 max_len;
	int                         n_computed;
	logic [kllc_pkg::LEN_W-1:0] longest_len;
	logic                       fail_flag;

	length_word_t lengths_due[$];
	int           err_cnt = 0;
	int           items_sent = 0;
	bit           idle_on = 1'b1;

	kraft_length_limited_code_lengths dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	// estimate k - log2(1.5)*m in Q16 for p = c/sum = m * 2^-k
	function automatic longint ideal_length_q(longint unsigned c, longint unsigned sum);
		longint unsigned n, r, m, term;
		int k;
		n = c;
		k = 0;
		while (n < sum) begin
			n = n << 1;
			k++;
		end
		r = n - sum;
		m = 1;
		for (int b = 0; b < FB; b++) begin
			r = r << 1;
			m = m << 1;
			if (r >= sum) begin
				r = r - sum;
				m = m | 1;
			end
		end
		term = (longint'(kllc_pkg::LOG2_C_Q30) * m + (64'd1 << 29)) >> kllc_pkg::C_FRAC;
		return (longint'(k) << FB) - longint'(term);
	endfunction

	// assign lengths for the loaded block
	task automatic compute_lengths();
		int lim, used;
		longint unsigned unit, spent, have;
		longint thr, v, lenq;
		lim = max_len < 1 ? 1 : (max_len > kllc_pkg::LIM_MAX ? kllc_pkg::LIM_MAX : max_len);
		unit = 64'd1 << lim;
		used = 0;
		spent = 0;
		thr = 28 << (FB - 6);
		n_computed = n_loaded;
		longest_len = 0;
		fail_flag = 1'b0;
		for (int i = 0; i < n_loaded; i++)
			if (sym_count[i] != 0) used++;
		if (used > unit) begin
			fail_flag = 1'b1;
			for (int i = 0; i < NSYM; i++) sym_len[i] = 0;
			return;
		end
		for (int i = 0; i < n_loaded; i++) begin
			if (sym_count[i] == 0) begin
				sym_len[i] = 0;
				continue;
			end
			sym_est[i] = ideal_length_q(sym_count[i], count_sum);
			v = sym_est[i] + (longint'(1) << (FB - 1));
			lenq = v < 0 ? 0 : (v >>> FB);
			if (lenq < 1) lenq = 1;
			if (lenq > lim) lenq = lim;
			sym_len[i] = lenq[kllc_pkg::LEN_W-1:0];
			spent += unit >> lenq;
		end
		// lengthen codes with a falling threshold until the sum fits
		while (spent > unit) begin
			for (int i = 0; i < n_loaded; i++) begin
				if (sym_len[i] == 0 || sym_len[i] >= lim) continue;
				if (sym_est[i] - (longint'(sym_len[i]) << FB) > thr) begin
					sym_len[i] = sym_len[i] + 5'd1;
					spent -= unit >> sym_len[i];
					if (spent <= unit) break;
				end
			end
			thr -= longint'(1) << (FB - 6);
		end
		// shorten codes into the remaining slack
		if (spent < unit) begin
			for (int i = 0; i < n_loaded; i++) begin
				if (sym_len[i] <= 1) continue;
				have = unit >> sym_len[i];
				if (unit - spent >= have) begin
					sym_len[i] = sym_len[i] - 5'd1;
					spent += have;
					if (spent == unit) break;
				end
			end
		end
		for (int i = 0; i < n_loaded; i++)
			if (sym_len[i] > longest_len) longest_len = sym_len[i];
	endtask

	// apply one accepted word to the calculator
	task automatic take_word(bit mode, logic [31:0] cnt, bit last, logic [8:0] idx);
		length_word_t w;
		if (mode == MODE_LOAD) begin
			if (n_loaded < NSYM) begin
				sym_count[n_loaded] = cnt;
				n_loaded++;
				count_sum += cnt;
			end
			if (last) begin
				compute_lengths();
				n_loaded = 0;
				count_sum = 0;
			end
		end else begin
			w.code = (!fail_flag && idx < n_computed) ? sym_len[idx] : '0;
			w.longest = fail_flag ? '0 : longest_len;
			w.failed = fail_flag;
			lengths_due.push_back(w);
		end
	endtask

	// send one word and wait for it to be taken
	task automatic send_word(bit mode, logic [31:0] cnt, bit last, logic [8:0] idx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tlast  <= last;
		s_tdata  <= {7'b0, idx, cnt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		take_word(mode, cnt, last, idx);
		items_sent++;
	endtask

	// read a symbol; count and last are don't-care noise here
	task automatic read_len(int idx);
		send_word(MODE_READ, $urandom, 1'($urandom_range(0, 1)), idx[8:0]);
	endtask

	// drain results so the block is idle
	task automatic wait_idle();
		read_len($urandom_range(0, 511));
		s_tvalid <= 1'b0;
		while (lengths_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_max_length(logic [4:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		max_len = v;
	endtask

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom_range(1, 15);
			2: return $urandom_range(1, 65535);
			3: return 32'd1 << $urandom_range(0, 31);
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// load n counts, then read a few lengths back
	task automatic run_block(int n, int reads);
		for (int i = 0; i < n; i++) begin
			send_word(MODE_LOAD, pick_count(), i == n - 1, 9'($urandom));
			// occasional read in the middle of a load
			if ($urandom_range(0, 30) == 0) read_len($urandom);
		end
		for (int i = 0; i < reads; i++)
			read_len($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, n));
	endtask

	task automatic test_field_extremes();
		send_word(MODE_LOAD, 32'hFFFF_FFFF, 1'b0, 9'h1FF);
		send_word(MODE_LOAD, 32'd1, 1'b0, 9'h000);
		send_word(MODE_LOAD, 32'd0, 1'b0, 9'h0AA);
		send_word(MODE_LOAD, 32'h8000_0000, 1'b1, 9'h155);
		for (int i = 0; i < 4; i++) read_len(i);
		read_len(9'h1FF);
	endtask

	task automatic test_reads_before_compute();
		read_len(0);
		read_len(9'h1FF);
	endtask

	task automatic test_all_zero();
		for (int i = 0; i < 5; i++) send_word(MODE_LOAD, 32'd0, i == 4, 9'($urandom));
		read_len(0);
		read_len(4);
	endtask

	task automatic test_too_many_used();
		set_max_length(5'd1);
		for (int i = 0; i < 3; i++) send_word(MODE_LOAD, i + 1, i == 2, 9'($urandom));
		read_len(0);
		read_len(2);
		for (int i = 0; i < 2; i++) send_word(MODE_LOAD, 32'd7, i == 1, 9'($urandom));
		read_len(0);
	endtask

	task automatic test_store_full();
		set_max_length(5'd24);
		for (int i = 0; i < NSYM + 8; i++)
			send_word(MODE_LOAD, $urandom_range(1, 1000), i == NSYM + 7, 9'($urandom));
		read_len(0);
		read_len(511);
	endtask

	task automatic test_limit_sweep();
		logic [4:0] lims [6] = '{5'd0, 5'd2, 5'd24, 5'd25, 5'd31, 5'd9};
		foreach (lims[j]) begin
			set_max_length(lims[j]);
			run_block($urandom_range(2, 40), 6);
		end
	endtask

	task automatic test_random_blocks();
		while (items_sent < 1400) begin
			if ($urandom_range(0, 9) == 0) set_max_length(5'($urandom_range(0, 31)));
			if (items_sent > 1200) idle_on = 1'b0;
			if ($urandom_range(0, 60) == 0)
				run_block($urandom_range(200, 512), 10);
			else
				run_block($urandom_range(2, 24), $urandom_range(2, 8));
		end
	endtask

	// receiver stalls in bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each read word with the oldest expectation
	always @(posedge clk) begin
		length_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (lengths_due.size() == 0) begin
				$display("%0t: unexpected word code=%0d longest=%0d failed=%0b",
					$time, m_tdata[4:0], m_tdata[9:5], m_tuser);
				err_cnt++;
			end else begin
				want = lengths_due.pop_front();
				if (m_tdata[4:0] !== want.code) begin
					$display("%0t: code_length expected %0d actual %0d",
						$time, want.code, m_tdata[4:0]);
					err_cnt++;
				end
				if (m_tdata[9:5] !== want.longest) begin
					$display("%0t: longest_length expected %0d actual %0d",
						$time, want.longest, m_tdata[9:5]);
					err_cnt++;
				end
				if (m_tuser !== want.failed) begin
					$display("%0t: failed expected %0b actual %0b",
						$time, want.failed, m_tuser);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		n_loaded = 0;
		count_sum = 0;
		max_len = 5'd15;
		n_computed = 0;
		longest_len = 0;
		fail_flag = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reads_before_compute();
		test_field_extremes();
		test_all_zero();
		test_too_many_used();
		test_limit_sweep();
		test_store_full();
		test_random_blocks();
		idle_on = 1'b0;
		wait_idle();
		if (lengths_due.size() != 0) err_cnt++;
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/kllc_pkg.sv
rtl/core/kllc_ram.sv
rtl/core/kraft_length_limited_code_lengths.sv
test/tb_top.sv
